FILE: rtl/key_click_long_press_detector_macros.svh
// Assertion macros for the key click and long-press detector.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef KEY_CLICK_LONG_PRESS_DETECTOR_MACROS_SVH
`define KEY_CLICK_LONG_PRESS_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCLPD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("key detector check failed");

// The consequent must hold in the cycle after the antecedent.
`define KCLPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("key detector check failed");

`endif

FILE: rtl/kclpd_pkg.sv
// Shared types, codes and reset values for the key click and long-press detector.
// No dependencies; used by kclpd_key and the top level.
package kclpd_pkg;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_PRESS   = 3'd1,
		PH_HELD    = 3'd2,
		PH_RELEASE = 3'd3,
		PH_GAP     = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_LONG   = 2'd2,
		EV_MULTI  = 2'd3
	} event_t;

	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_DEBOUNCE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS       = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_DEBOUNCE = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_GAP        = 2'd3;

	localparam logic [7:0] PRESS_DEBOUNCE_RESET   = 8'd5;
	localparam logic [7:0] LONG_PRESS_RESET       = 8'd30;
	localparam logic [7:0] RELEASE_DEBOUNCE_RESET = 8'd5;
	localparam logic [7:0] CLICK_GAP_RESET        = 8'd10;

	typedef struct packed {
		logic [7:0] press_debounce;
		logic [7:0] long_press;
		logic [7:0] release_debounce;
		logic [7:0] click_gap;
	} thresholds_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

FILE: rtl/kclpd_key.sv
// Per-key debounce, click counting and long-press state machine.
// Depends on kclpd_pkg for the phase and event codes and the threshold struct.
module kclpd_key
	import kclpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic        pressed,
	input  thresholds_t thr,
	output event_t      ev_next,
	output logic [7:0]  clicks_next
);

	phase_t     phase_q, phase_d;
	logic [7:0] hold_q, hold_d;
	logic [7:0] release_q, release_d;
	logic [7:0] gap_q, gap_d;
	logic [7:0] tally_q, tally_d;
	logic       long_q, long_d;
	logic [7:0] last_q, last_d;

	logic [7:0] hold_inc, release_inc, gap_inc;

	assign hold_inc    = sat_inc(hold_q);
	assign release_inc = sat_inc(release_q);
	assign gap_inc     = sat_inc(gap_q);

	always_comb begin
		phase_d   = phase_q;
		hold_d    = hold_q;
		release_d = release_q;
		gap_d     = gap_q;
		tally_d   = tally_q;
		long_d    = long_q;
		last_d    = last_q;
		case (phase_q)
			PH_PRESS: begin
				if (!pressed) begin
					phase_d = PH_IDLE;
					hold_d  = 8'd0;
				end else if (hold_inc >= thr.press_debounce) begin
					phase_d = PH_HELD;
					hold_d  = 8'd0;
					long_d  = 1'b0;
				end else begin
					hold_d = hold_inc;
				end
			end
			PH_HELD: begin
				if (pressed) begin
					hold_d = hold_inc;
					if (!long_q && hold_inc >= thr.long_press) begin
						long_d = 1'b1;
					end
				end else begin
					release_d = 8'd0;
					phase_d   = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (!pressed) begin
					release_d = release_inc;
					if (release_inc >= thr.release_debounce) begin
						if (!long_q) begin
							tally_d = sat_inc(tally_q);
							gap_d   = 8'd0;
							phase_d = PH_GAP;
						end else begin
							// A long press ends its sequence without counting a click.
							long_d  = 1'b0;
							tally_d = 8'd0;
							phase_d = PH_IDLE;
						end
					end
				end else begin
					release_d = 8'd0;
					hold_d    = 8'd0;
				end
			end
			PH_GAP: begin
				gap_d = gap_inc;
				if (pressed) begin
					hold_d  = 8'd0;
					phase_d = PH_PRESS;
				end else if (gap_inc >= thr.click_gap) begin
					last_d    = tally_q;
					tally_d   = 8'd0;
					gap_d     = 8'd0;
					hold_d    = 8'd0;
					release_d = 8'd0;
					phase_d   = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (pressed) begin
					phase_d = PH_PRESS;
					hold_d  = 8'd0;
				end
			end
		endcase
	end

	always_comb begin
		ev_next = EV_NONE;
		case (phase_q)
			PH_HELD: begin
				if (pressed && !long_q && hold_inc >= thr.long_press) begin
					ev_next = EV_LONG;
				end
			end
			PH_GAP: begin
				if (!pressed && gap_inc >= thr.click_gap) begin
					ev_next = (tally_q == 8'd1) ? EV_SINGLE : EV_MULTI;
				end
			end
			default: begin
				ev_next = EV_NONE;
			end
		endcase
	end

	assign clicks_next = last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			hold_q    <= 8'd0;
			release_q <= 8'd0;
			gap_q     <= 8'd0;
			tally_q   <= 8'd0;
			long_q    <= 1'b0;
			last_q    <= 8'd0;
		end else if (advance) begin
			phase_q   <= phase_d;
			hold_q    <= hold_d;
			release_q <= release_d;
			gap_q     <= gap_d;
			tally_q   <= tally_d;
			long_q    <= long_d;
			last_q    <= last_d;
		end
	end

endmodule

FILE: rtl/key_click_long_press_detector.sv
// Top level of the four-key click and long-press detector.
// Depends on kclpd_pkg, kclpd_key and key_click_long_press_detector_macros.svh.
//
// Each accepted input beat is one tick carrying a pressed level per key, and
// it yields exactly one result beat with an event code and the last finished
// click count for every key. A tick updates all key state machines in the
// cycle it is accepted; its result is registered in the output register or
// in the one-entry skid register while that beat is stalled. A new tick can
// be taken every clock unless input is stalled, which happens only once both
// registers hold untaken results. Keys at or above NUM_KEYS report no event
// and zero clicks. Thresholds are written through the always-ready config port;
// the user must write them only while idle; the block does not enforce it.
`include "key_click_long_press_detector_macros.svh"

module key_click_long_press_detector
	import kclpd_pkg::*;
#(
	parameter int NUM_KEYS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   key0_pressed,
	input  logic                   key1_pressed,
	input  logic                   key2_pressed,
	input  logic                   key3_pressed,

	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             key0_event,
	output logic [1:0]             key1_event,
	output logic [1:0]             key2_event,
	output logic [1:0]             key3_event,
	output logic [7:0]             key0_clicks,
	output logic [7:0]             key1_clicks,
	output logic [7:0]             key2_clicks,
	output logic [7:0]             key3_clicks,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data
);

	localparam int KEY_SLOTS = 4;

	thresholds_t thr_q;

	logic                            accept;
	logic                            out_fire;
	logic [KEY_SLOTS-1:0]            pressed;
	logic [KEY_SLOTS-1:0][1:0]       ev_next;
	logic [KEY_SLOTS-1:0][7:0]       clicks_next;

	logic                            out_valid_q;
	logic [KEY_SLOTS-1:0][1:0]       out_ev_q;
	logic [KEY_SLOTS-1:0][7:0]       out_clicks_q;
	logic                            skid_valid_q;
	logic [KEY_SLOTS-1:0][1:0]       skid_ev_q;
	logic [KEY_SLOTS-1:0][7:0]       skid_clicks_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.press_debounce   <= PRESS_DEBOUNCE_RESET;
			thr_q.long_press       <= LONG_PRESS_RESET;
			thr_q.release_debounce <= RELEASE_DEBOUNCE_RESET;
			thr_q.click_gap        <= CLICK_GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PRESS_DEBOUNCE:   thr_q.press_debounce   <= cfg_data;
				CFG_LONG_PRESS:       thr_q.long_press       <= cfg_data;
				CFG_RELEASE_DEBOUNCE: thr_q.release_debounce <= cfg_data;
				CFG_CLICK_GAP:        thr_q.click_gap        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign pressed  = {key3_pressed, key2_pressed, key1_pressed, key0_pressed};
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;

	for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_key
		if (k < NUM_KEYS) begin : g_used
			event_t key_ev;

			kclpd_key u_key (
				.clk         (clk),
				.arst_n      (arst_n),
				.advance     (accept),
				.pressed     (pressed[k]),
				.thr         (thr_q),
				.ev_next     (key_ev),
				.clicks_next (clicks_next[k])
			);

			assign ev_next[k] = key_ev;
		end else begin : g_unused
			assign ev_next[k]     = EV_NONE;
			assign clicks_next[k] = 8'd0;
		end
	end

	// A new result goes straight to the output register unless that register
	// still holds a beat that is being stalled; then it waits in the skid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			out_valid_q <= 1'b1;
			if (out_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_ev_q     <= skid_ev_q;
				out_clicks_q <= skid_clicks_q;
			end
		end else if (accept) begin
			if (!out_valid_q || out_fire) begin
				out_ev_q     <= ev_next;
				out_clicks_q <= clicks_next;
			end else begin
				skid_ev_q     <= ev_next;
				skid_clicks_q <= clicks_next;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign key0_event  = out_ev_q[0];
	assign key1_event  = out_ev_q[1];
	assign key2_event  = out_ev_q[2];
	assign key3_event  = out_ev_q[3];
	assign key0_clicks = out_clicks_q[0];
	assign key1_clicks = out_clicks_q[1];
	assign key2_clicks = out_clicks_q[2];
	assign key3_clicks = out_clicks_q[3];

	// The skid register only fills behind an occupied output register.
	`KCLPD_ASSERT_SAME(a_skid_behind_out, skid_valid_q, out_valid_q)

	// A tick taken while the output beat is stalled must land in the skid.
	`KCLPD_ASSERT_NEXT(a_stalled_accept_kept, accept && out_valid_q && out_stall, skid_valid_q)

	// With nothing buffered and nothing accepted, a delivered beat empties the output.
	`KCLPD_ASSERT_NEXT(a_drain_empties, out_fire && !skid_valid_q && !accept, !out_valid_q)

endmodule

FILE: test/tb_key_click_long_press_detector.sv
// Testbench for key_click_long_press_detector: tick beats with random flow control,
// each result beat checked against a behavioural model of the four key machines.
// Depends on kclpd_pkg and the detector RTL.
`timescale 1ns / 100ps

module tb_key_click_long_press_detector
	import kclpd_pkg::*;
();

	localparam int HOLD_OFF_CYCLES = 60;

	typedef struct packed {
		logic [3:0][1:0] events;
		logic [3:0][7:0] clicks;
	} key_report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic key0_pressed, key1_pressed, key2_pressed, key3_pressed;
	logic out_valid;
	logic out_stall;
	logic [1:0] key0_event, key1_event, key2_event, key3_event;
	logic [7:0] key0_clicks, key1_clicks, key2_clicks, key3_clicks;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [7:0] cfg_data;

	// Model state for every key, and its copy of the thresholds.
	phase_t key_phase [4];
	logic [7:0] hold_cnt [4];
	logic [7:0] release_cnt [4];
	logic [7:0] gap_cnt [4];
	logic [7:0] tally_cnt [4];
	logic [7:0] last_clicks [4];
	bit long_fired [4];
	logic [7:0] thr_press = PRESS_DEBOUNCE_RESET;
	logic [7:0] thr_long = LONG_PRESS_RESET;
	logic [7:0] thr_release = RELEASE_DEBOUNCE_RESET;
	logic [7:0] thr_gap = CLICK_GAP_RESET;

	key_report_t pending_reports [$];
	int ticks_sent = 0;
	int reports_seen = 0;
	int bad_reports = 0;
	int burst_left = 0;
	bit steady = 1'b0;
	bit hold_off_pending = 1'b0;

	key_click_long_press_detector #(.NUM_KEYS(4)) dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		for (int k = 0; k < 4; k++) begin
			key_phase[k] = PH_IDLE;
			hold_cnt[k] = '0;
			release_cnt[k] = '0;
			gap_cnt[k] = '0;
			tally_cnt[k] = '0;
			last_clicks[k] = '0;
			long_fired[k] = 1'b0;
		end
	end

	function automatic logic [7:0] count_up(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	// One tick of one key machine; returns the event it raises on this tick.
	function automatic event_t advance_key(input int k, input bit down);
		event_t ev;
		ev = EV_NONE;
		case (key_phase[k])
		PH_PRESS: begin
			if (!down) begin
				key_phase[k] = PH_IDLE;
				hold_cnt[k] = '0;
			end else begin
				hold_cnt[k] = count_up(hold_cnt[k]);
				if (hold_cnt[k] >= thr_press) begin
					key_phase[k] = PH_HELD;
					hold_cnt[k] = '0;
					long_fired[k] = 1'b0;
				end
			end
		end
		PH_HELD: begin
			if (down) begin
				hold_cnt[k] = count_up(hold_cnt[k]);
				if (!long_fired[k] && hold_cnt[k] >= thr_long) begin
					long_fired[k] = 1'b1;
					ev = EV_LONG;
				end
			end else begin
				release_cnt[k] = '0;
				key_phase[k] = PH_RELEASE;
			end
		end
		PH_RELEASE: begin
			if (!down) begin
				release_cnt[k] = count_up(release_cnt[k]);
				if (release_cnt[k] >= thr_release) begin
					if (!long_fired[k]) begin
						tally_cnt[k] = count_up(tally_cnt[k]);
						gap_cnt[k] = '0;
						key_phase[k] = PH_GAP;
					end else begin
						// A long press ends the sequence without reporting a click.
						long_fired[k] = 1'b0;
						tally_cnt[k] = '0;
						key_phase[k] = PH_IDLE;
					end
				end
			end else begin
				release_cnt[k] = '0;
				hold_cnt[k] = '0;
			end
		end
		PH_GAP: begin
			gap_cnt[k] = count_up(gap_cnt[k]);
			if (down) begin
				hold_cnt[k] = '0;
				key_phase[k] = PH_PRESS;
			end else if (gap_cnt[k] >= thr_gap) begin
				ev = (tally_cnt[k] == 8'd1) ? EV_SINGLE : EV_MULTI;
				last_clicks[k] = tally_cnt[k];
				tally_cnt[k] = '0;
				gap_cnt[k] = '0;
				hold_cnt[k] = '0;
				release_cnt[k] = '0;
				key_phase[k] = PH_IDLE;
			end
		end
		default: begin
			key_phase[k] = down ? PH_PRESS : PH_IDLE;
			if (down)
				hold_cnt[k] = '0;
		end
		endcase
		return ev;
	endfunction

	// Follows register writes and accepted tick beats, queueing the expected result.
	always @(posedge clk) begin : tick_model
		logic [3:0] down;
		key_report_t forecast;
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
			CFG_PRESS_DEBOUNCE: thr_press = cfg_data;
			CFG_LONG_PRESS: thr_long = cfg_data;
			CFG_RELEASE_DEBOUNCE: thr_release = cfg_data;
			CFG_CLICK_GAP: thr_gap = cfg_data;
			default: ;
			endcase
		end
		if (arst_n && in_valid && !in_stall) begin
			down = {key3_pressed, key2_pressed, key1_pressed, key0_pressed};
			for (int k = 0; k < 4; k++) begin
				forecast.events[k] = advance_key(k, down[k]);
				forecast.clicks[k] = last_clicks[k];
			end
			pending_reports.push_back(forecast);
		end
	end

	task automatic note_failure(input string msg);
		bad_reports++;
		if (bad_reports <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin : report_check
		key_report_t seen, want;
		if (arst_n && out_valid && !out_stall) begin
			seen.events = {key3_event, key2_event, key1_event, key0_event};
			seen.clicks = {key3_clicks, key2_clicks, key1_clicks, key0_clicks};
			reports_seen++;
			if (pending_reports.size() == 0) begin
				note_failure($sformatf("result beat %0d arrived with nothing expected",
					reports_seen));
			end else begin
				want = pending_reports.pop_front();
				for (int k = 0; k < 4; k++) begin
					if (seen.events[k] !== want.events[k])
						note_failure($sformatf("beat %0d key%0d event: expected %0d, got %0d",
							reports_seen, k, want.events[k], seen.events[k]));
					if (seen.clicks[k] !== want.clicks[k])
						note_failure($sformatf("beat %0d key%0d clicks: expected %0d, got %0d",
							reports_seen, k, want.clicks[k], seen.clicks[k]));
				end
			end
		end
	end

	// Receiver stall pattern; a requested hold-off overrides it for a fixed stretch.
	initial begin : drain_pattern
		int mode, mode_left, hold_left;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 99) < 30);
				2: out_stall <= (mode_left % 3 == 0);
				default: out_stall <= ($urandom_range(0, 99) < 70);
				endcase
			end
		end
	end

	// Offers one tick beat and returns once it has been taken.
	task automatic send_tick(input logic [3:0] keys);
		int gap;
		if (!steady && burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		key0_pressed <= keys[0];
		key1_pressed <= keys[1];
		key2_pressed <= keys[2];
		key3_pressed <= keys[3];
		do @(posedge clk); while (in_stall);
		ticks_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (reports_seen < ticks_sent)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_thresholds(input logic [7:0] press, input logic [7:0] long_hold,
		input logic [7:0] release_ticks, input logic [7:0] gap);
		drain();
		write_reg(CFG_PRESS_DEBOUNCE, press);
		write_reg(CFG_LONG_PRESS, long_hold);
		write_reg(CFG_RELEASE_DEBOUNCE, release_ticks);
		write_reg(CFG_CLICK_GAP, gap);
		cfg_valid <= 1'b0;
	endtask

	// Level run lengths cluster around the thresholds so that every boundary is hit.
	function automatic int run_length(input bit pressed);
		int pick, base;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			return $urandom_range(1, 3);
		if (pressed)
			base = (pick < 6) ? int'(thr_press) : int'(thr_press) + int'(thr_long);
		else
			base = (pick < 6) ? int'(thr_release) : int'(thr_release) + int'(thr_gap);
		return $urandom_range(base + 2, (base > 2) ? base - 1 : 1);
	endfunction

	task automatic run_random(input int count);
		bit level [4];
		int left [4];
		logic [3:0] keys;
		for (int k = 0; k < 4; k++) begin
			level[k] = $urandom_range(0, 1);
			left[k] = 0;
		end
		repeat (count) begin
			for (int k = 0; k < 4; k++) begin
				if (left[k] == 0) begin
					level[k] = !level[k];
					left[k] = run_length(level[k]);
				end
				left[k]--;
				keys[k] = level[k];
			end
			// Occasional single-tick glitch on one key.
			if ($urandom_range(0, 24) == 0)
				keys[$urandom_range(0, 3)] ^= 1'b1;
			send_tick(keys);
		end
	endtask

	// With every threshold at one: key 0 clicks once, key 1 twice, key 2 clicks and then
	// long-presses inside the gap, key 3 is pressed again during release debounce.
	task automatic test_directed_events();
		logic [3:0] pattern [12] = '{4'hF, 4'hF, 4'h0, 4'h8, 4'h6, 4'h6, 4'h4,
			4'h0, 4'h0, 4'h0, 4'h0, 4'h0};
		set_thresholds(8'd1, 8'd1, 8'd1, 8'd1);
		foreach (pattern[t])
			send_tick(pattern[t]);
	endtask

	task automatic test_back_pressure();
		steady = 1'b1;
		hold_off_pending = 1'b1;
		repeat (40) send_tick(4'($urandom_range(0, 15)));
		steady = 1'b0;
	endtask

	// Long-press limit at its maximum: key 0 holds long enough to saturate the hold count,
	// key 1 reaches the limit on its last tick and key 2 misses it by one.
	task automatic test_long_hold();
		logic [3:0] keys;
		set_thresholds(8'd1, 8'd255, 8'd1, 8'd1);
		for (int t = 0; t < 304; t++) begin
			keys[0] = (t < 300);
			keys[1] = (t < 257);
			keys[2] = (t < 256);
			keys[3] = $urandom_range(0, 1);
			send_tick(keys);
		end
	endtask

	// Key 0 clicks forty times in one sequence and key 1 thirty-seven times.
	task automatic test_click_runs();
		logic [3:0] keys;
		set_thresholds(8'd1, 8'd1, 8'd1, 8'd1);
		for (int t = 0; t < 164; t++) begin
			keys[0] = (t < 160) && (t % 4 < 2);
			keys[1] = (t < 148) && (t % 4 < 2);
			keys[2] = $urandom_range(0, 1);
			keys[3] = (t % 7 < 3);
			send_tick(keys);
		end
	endtask

	task automatic test_random_settings();
		set_thresholds(PRESS_DEBOUNCE_RESET, LONG_PRESS_RESET, RELEASE_DEBOUNCE_RESET,
			CLICK_GAP_RESET);
		run_random(60);
		set_thresholds(8'd1, 8'd1, 8'd1, 8'd1);
		run_random(50);
		set_thresholds(8'd255, 8'd255, 8'd255, 8'd255);
		run_random(60);
		set_thresholds(8'd2, 8'd3, 8'd2, 8'd4);
		run_random(50);
		repeat (2) begin
			set_thresholds(8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
				8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)));
			run_random(55);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		key0_pressed <= 1'b0;
		key1_pressed <= 1'b0;
		key2_pressed <= 1'b0;
		key3_pressed <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_PRESS_DEBOUNCE;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_events();
		test_back_pressure();
		test_long_hold();
		test_click_runs();
		test_random_settings();
		drain();
		repeat (4) @(posedge clk);
		if (bad_reports == 0 && pending_reports.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: key_click_long_press_detector.f
+incdir+rtl
rtl/kclpd_pkg.sv
rtl/kclpd_key.sv
rtl/key_click_long_press_detector.sv
test/tb_key_click_long_press_detector.sv
